/* rtl/xxh64_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_pkg
// Shared constants, item classes and queue entry type of the xxHash64 hasher.
// ----------------------------------------------------------------------------
package xxh64_pkg;

	localparam logic [63:0] P1 = 64'd11400714785074694791;
	localparam logic [63:0] P2 = 64'd14029467366897019727;
	localparam logic [63:0] P3 = 64'd1609587929392839161;
	localparam logic [63:0] P4 = 64'd9650029242287828579;
	localparam logic [63:0] P5 = 64'd2870177450012600261;

	localparam int LENGTH_BITS_DEF = 64;

	// what the back end does with one request
	typedef enum logic [1:0] {
		KIND_WORD      = 2'd0,  // full word, message continues
		KIND_LAST_FULL = 2'd1,  // full word, then finish with no tail
		KIND_LAST_PART = 2'd2   // finish with the word as a 0..7 byte tail
	} kind_t;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		kind_t       kind;
	} entry_t;

	function automatic logic [63:0] rol64(input logic [63:0] v, input int r);
		rol64 = (v << r) | (v >> (64 - r));
	endfunction

endpackage

/* rtl/xxh64_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_front
// Input side: classify each request and push it into the queue.
// ----------------------------------------------------------------------------
module xxh64_front (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        data_word,
	input  logic [3:0]         byte_count,
	input  logic               last,
	input  logic               q_full,
	output logic               q_push,
	output xxh64_pkg::entry_t  q_entry
);
	import xxh64_pkg::*;

	logic [3:0] n_sat;

	assign n_sat    = (byte_count > 4'd8) ? 4'd8 : byte_count;
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_entry.word = data_word;
		if (!last) begin
			q_entry.kind   = KIND_WORD;
			q_entry.nbytes = 4'd0;
		end else if (n_sat == 4'd8) begin
			q_entry.kind   = KIND_LAST_FULL;
			q_entry.nbytes = 4'd0;
		end else begin
			q_entry.kind   = KIND_LAST_PART;
			q_entry.nbytes = n_sat;
		end
	end

endmodule

/* rtl/xxh64_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module xxh64_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  xxh64_pkg::entry_t  push_entry,
	input  logic               pop,
	output xxh64_pkg::entry_t  head,
	output logic               full,
	output logic               empty
);
	import xxh64_pkg::*;

	entry_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* rtl/xxh64_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_mul
// 64x64 multiply modulo 2^64 on one 32x32 multiplier, one partial product at a time.
// ----------------------------------------------------------------------------
module xxh64_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;

	// low x low, then the two cross terms into the upper half
	always_comb begin
		case (step_q)
			2'd0:    begin ma = a_q[31:0];  mb = b_q[31:0];  end
			2'd1:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
			default: begin ma = a_q[63:32]; mb = b_q[31:0];  end
		endcase
	end

	assign prod = {32'd0, ma} * {32'd0, mb};
	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'd0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/xxh64_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_back
// Back end: stripe buffering, lane rounds, finalization and result register.
// ----------------------------------------------------------------------------
module xxh64_back #(
	parameter int LENGTH_BITS = xxh64_pkg::LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [63:0]        seed,
	input  xxh64_pkg::entry_t  head,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        hash
);
	import xxh64_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PUSH, ST_ABS_A, ST_ABS_B, ST_FIN, ST_MRG_ROT,
		ST_MRG_M1, ST_MRG_M2, ST_MRG_M3, ST_ADDLEN, ST_WRD_M1, ST_WRD_M2,
		ST_WRD_M3, ST_TAIL, ST_T4_M1, ST_T4_M2, ST_BYTE_CHK, ST_B_M1, ST_B_M2,
		ST_AV1, ST_AV_M1, ST_AV_M2, ST_OUT
	} state_t;

	state_t                  state_q;
	logic [63:0]             acc_q [4];
	logic [63:0]             buf_q [4];
	logic [1:0]              slot_q;
	logic [LENGTH_BITS-1:0]  bt_q;
	logic                    sdone_q;
	logic [1:0]              lane_q;
	logic [3:0]              bidx_q;
	logic [63:0]             word_q;
	logic [3:0]              n_q;
	kind_t                   kind_q;
	logic [63:0]             h_q;
	logic [63:0]             t_q;
	logic                    pend_q;
	logic                    out_valid_q;
	logic [63:0]             out_hash_q;

	logic                    mul_stage;
	logic                    mul_start;
	logic                    mul_done;
	logic [63:0]             mul_a;
	logic [63:0]             mul_b;
	logic [63:0]             mul_p;
	logic [63:0]             mrg_rot;
	logic [7:0]              tail_byte;
	logic                    fire;

	assign m_tvalid  = out_valid_q;
	assign hash      = out_hash_q;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign fire      = pend_q && mul_done;
	assign tail_byte = 8'(word_q >> {bidx_q[2:0], 3'b000});

	always_comb begin
		case (lane_q)
			2'd0:    mrg_rot = rol64(acc_q[0], 1);
			2'd1:    mrg_rot = rol64(acc_q[1], 7);
			2'd2:    mrg_rot = rol64(acc_q[2], 12);
			default: mrg_rot = rol64(acc_q[3], 18);
		endcase
	end

	// operand select for the states that use the multiplier
	always_comb begin
		mul_stage = 1'b1;
		mul_a     = h_q;
		mul_b     = P1;
		unique case (state_q)
			ST_ABS_A:  begin mul_a = buf_q[lane_q]; mul_b = P2; end
			ST_ABS_B:  begin mul_a = rol64(t_q, 31); mul_b = P1; end
			ST_MRG_M1: begin mul_a = acc_q[lane_q]; mul_b = P2; end
			ST_MRG_M2: begin mul_a = t_q; mul_b = P1; end
			ST_MRG_M3: begin mul_a = h_q; mul_b = P1; end
			ST_WRD_M1: begin mul_a = buf_q[lane_q]; mul_b = P2; end
			ST_WRD_M2: begin mul_a = t_q; mul_b = P1; end
			ST_WRD_M3: begin mul_a = rol64(h_q, 27); mul_b = P1; end
			ST_T4_M1:  begin mul_a = {32'd0, word_q[31:0]}; mul_b = P1; end
			ST_T4_M2:  begin mul_a = rol64(h_q, 23); mul_b = P2; end
			ST_B_M1:   begin mul_a = {56'd0, tail_byte}; mul_b = P5; end
			ST_B_M2:   begin mul_a = rol64(h_q, 11); mul_b = P1; end
			ST_AV_M1:  begin mul_a = h_q; mul_b = P2; end
			ST_AV_M2:  begin mul_a = h_q; mul_b = P3; end
			default:   mul_stage = 1'b0;
		endcase
	end

	assign mul_start = mul_stage && !pend_q;

	xxh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// stripe buffer holds payload only: every entry is written before it is read
	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH) begin
			buf_q[slot_q] <= word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= 2'd0;
			bt_q        <= '0;
			sdone_q     <= 1'b0;
			lane_q      <= 2'd0;
			bidx_q      <= 4'd0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			word_q      <= '0;
			n_q         <= '0;
			kind_q      <= KIND_WORD;
			h_q         <= '0;
			t_q         <= '0;
			out_hash_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if ((state_q == ST_OUT) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_start) begin
				pend_q <= 1'b1;
			end else if (fire) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						word_q  <= head.word;
						n_q     <= head.nbytes;
						kind_q  <= head.kind;
						state_q <= (head.kind == KIND_LAST_PART) ? ST_FIN : ST_PUSH;
					end
				end
				ST_PUSH: begin
					bt_q <= bt_q + LENGTH_BITS'(8);
					if (slot_q == 2'd3) begin
						slot_q <= 2'd0;
						lane_q <= 2'd0;
						if (!sdone_q) begin
							acc_q[0] <= seed + P1 + P2;
							acc_q[1] <= seed + P2;
							acc_q[2] <= seed;
							acc_q[3] <= seed - P1;
						end
						state_q <= ST_ABS_A;
					end else begin
						slot_q  <= slot_q + 2'd1;
						state_q <= (kind_q == KIND_WORD) ? ST_IDLE : ST_FIN;
					end
				end
				ST_ABS_A: begin
					if (fire) begin
						t_q     <= acc_q[lane_q] + mul_p;
						state_q <= ST_ABS_B;
					end
				end
				ST_ABS_B: begin
					if (fire) begin
						acc_q[lane_q] <= mul_p;
						lane_q        <= lane_q + 2'd1;
						if (lane_q == 2'd3) begin
							sdone_q <= 1'b1;
							state_q <= (kind_q == KIND_WORD) ? ST_IDLE : ST_FIN;
						end else begin
							state_q <= ST_ABS_A;
						end
					end
				end
				ST_FIN: begin
					bt_q   <= bt_q + LENGTH_BITS'(n_q);
					lane_q <= 2'd0;
					if (sdone_q) begin
						h_q     <= '0;
						state_q <= ST_MRG_ROT;
					end else begin
						h_q     <= seed + P5;
						state_q <= ST_ADDLEN;
					end
				end
				ST_MRG_ROT: begin
					h_q    <= h_q + mrg_rot;
					lane_q <= lane_q + 2'd1;
					if (lane_q == 2'd3) begin
						state_q <= ST_MRG_M1;
					end
				end
				ST_MRG_M1: begin
					if (fire) begin
						t_q     <= rol64(mul_p, 31);
						state_q <= ST_MRG_M2;
					end
				end
				ST_MRG_M2: begin
					if (fire) begin
						h_q     <= h_q ^ mul_p;
						state_q <= ST_MRG_M3;
					end
				end
				ST_MRG_M3: begin
					if (fire) begin
						h_q     <= mul_p + P4;
						lane_q  <= lane_q + 2'd1;
						state_q <= (lane_q == 2'd3) ? ST_ADDLEN : ST_MRG_M1;
					end
				end
				ST_ADDLEN: begin
					h_q     <= h_q + 64'(bt_q);
					lane_q  <= 2'd0;
					state_q <= (slot_q != 2'd0) ? ST_WRD_M1 : ST_TAIL;
				end
				ST_WRD_M1: begin
					if (fire) begin
						t_q     <= rol64(mul_p, 31);
						state_q <= ST_WRD_M2;
					end
				end
				ST_WRD_M2: begin
					if (fire) begin
						h_q     <= h_q ^ mul_p;
						state_q <= ST_WRD_M3;
					end
				end
				ST_WRD_M3: begin
					if (fire) begin
						h_q     <= mul_p + P4;
						lane_q  <= lane_q + 2'd1;
						state_q <= (lane_q == slot_q - 2'd1) ? ST_TAIL : ST_WRD_M1;
					end
				end
				ST_TAIL: begin
					bidx_q  <= 4'd0;
					state_q <= (n_q >= 4'd4) ? ST_T4_M1 : ST_BYTE_CHK;
				end
				ST_T4_M1: begin
					if (fire) begin
						h_q     <= h_q ^ mul_p;
						state_q <= ST_T4_M2;
					end
				end
				ST_T4_M2: begin
					if (fire) begin
						h_q     <= mul_p + P3;
						bidx_q  <= 4'd4;
						state_q <= ST_BYTE_CHK;
					end
				end
				ST_BYTE_CHK: begin
					state_q <= (bidx_q < n_q) ? ST_B_M1 : ST_AV1;
				end
				ST_B_M1: begin
					if (fire) begin
						h_q     <= h_q ^ mul_p;
						state_q <= ST_B_M2;
					end
				end
				ST_B_M2: begin
					if (fire) begin
						h_q     <= mul_p;
						bidx_q  <= bidx_q + 4'd1;
						state_q <= ST_BYTE_CHK;
					end
				end
				ST_AV1: begin
					h_q     <= h_q ^ (h_q >> 33);
					state_q <= ST_AV_M1;
				end
				ST_AV_M1: begin
					if (fire) begin
						h_q     <= mul_p ^ (mul_p >> 29);
						state_q <= ST_AV_M2;
					end
				end
				ST_AV_M2: begin
					if (fire) begin
						h_q     <= mul_p ^ (mul_p >> 32);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_hash_q  <= h_q;
						slot_q      <= 2'd0;
						bt_q        <= '0;
						sdone_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/xxh64_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_unit
// Streaming XXH64 of messages sent as little-endian 8-byte words.
// ----------------------------------------------------------------------------
// Usage: send a message as words on the slave stream, first byte in bits
// 7:0, and mark its final word with tlast; tdata[67:64] gives the valid
// bytes of that final word (above eight counts as eight, zero ends the
// message with what came before). One 64-bit hash comes out on the master
// stream per message. The seed is written through cfg_we/cfg_wdata while
// the block is idle. Operation: every product runs on one 32x32 multiplier
// in three steps, and a state that needs a product holds while it is issued,
// built in those steps and taken. A word that does not close a stripe passes
// through the idle and push states, a word closing a stripe adds the four
// lane rounds, and finishing runs the lane merge (after a full stripe), one
// round per buffered word, a 4-byte piece, single bytes and the avalanche.
// A two entry queue lets the input keep accepting while the back end works,
// and a result register holds the hash while the next message starts.
// ----------------------------------------------------------------------------
module xxhash64_stream_hasher_unit #(
	parameter int LENGTH_BITS = xxh64_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,     // seed
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,       // [63:0] data_word, [67:64] byte_count, zero pad
	input  logic        s_tlast,       // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata        // [63:0] hash
);
	import xxh64_pkg::*;

	logic [63:0] seed_q;
	entry_t      push_entry;
	entry_t      head;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	// hold the seed; it is sampled when lanes start and at short-message finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// classify each request and push it to the queue
	xxh64_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.data_word  (s_tdata[63:0]),
		.byte_count (s_tdata[67:64]),
		.last       (s_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry)
	);

	xxh64_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	// stripe rounds, finalization and the result register
	xxh64_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed_q),
		.head     (head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.hash     (m_tdata)
	);

endmodule
